// File: design/pgtk_pkg.sv
// Shared types, codes and helpers of the per-group top-k score table.
`default_nettype none

package pgtk_pkg;

    // Width of the name field in bytes and the name every entry holds after reset
    localparam int unsigned NAME_BYTES = 3;
    localparam logic [23:0] RESET_NAME = 24'h2D2D2D;

    // Request kinds carried in the slave tuser
    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_PROBE   = 2'd1,
        ACT_READ    = 2'd2,
        ACT_UNKNOWN = 2'd3
    } t_action;

    // Result codes carried in the master tuser
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISS    = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;   // capture the accepted request
        logic fetch;  // read the addressed group row
        logic exec;   // compare, update the row and load the result register
    } t_cmd;

    // Keep the leading nchars bytes, stop at the first zero byte
    function automatic logic [23:0] trim_name(input logic [23:0] raw, input int nchars);
        logic [23:0] kept;
        logic        ended;
        logic [7:0]  ch;
        kept  = '0;
        ended = 1'b0;
        for (int i = 0; i < NAME_BYTES; i++) begin
            ch = raw[8*(NAME_BYTES-1-i) +: 8];
            if (ch == 8'd0 || i >= nchars) begin
                ended = 1'b1;
            end
            if (!ended) begin
                kept[8*(NAME_BYTES-1-i) +: 8] = ch;
            end
        end
        return kept;
    endfunction

endpackage

`default_nettype wire

// File: design/pgtk_ctrl.sv
// Controller of the top-k table: sequences fetch and execute and owns the result valid.
`default_nettype none

module pgtk_ctrl (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             s_axis_tvalid,
    output logic            s_axis_tready,
    output logic            m_axis_tvalid,
    input  wire             m_axis_tready,
    output pgtk_pkg::t_cmd  o_cmd
);
    import pgtk_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_out_free;

    // Result register can take a new transaction this cycle
    assign w_out_free = !r_out_valid || m_axis_tready;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        s_axis_tready = 1'b0;
        o_cmd         = '0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.load    = s_axis_tvalid;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            S_EXEC: begin
                o_cmd.exec = w_out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Result valid: set on execute, drop once the transaction is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end
    end

    assign m_axis_tvalid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

// File: design/pgtk_datapath.sv
// Datapath of the top-k table: row memory, rank search, shift-insert and result register.
`default_nettype none

module pgtk_datapath #(
    parameter int GROUPS     = 3,
    parameter int SLOTS      = 3,
    parameter int NAME_CHARS = 3
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  pgtk_pkg::t_cmd  i_cmd,
    input  wire  [1:0]      i_action,
    input  wire  [1:0]      i_group,
    input  wire  [1:0]      i_slot,
    input  wire  [23:0]     i_entry_name,
    input  wire  [31:0]     i_entry_score,
    output logic [1:0]      o_status,
    output logic [1:0]      o_rank,
    output logic [23:0]     o_read_name,
    output logic [31:0]     o_read_score
);
    import pgtk_pkg::*;

    localparam int GW  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GXW = (GW > 2) ? GW : 2;
    localparam int SXW = (SW > 2) ? SW : 2;

    // Row memory: one row per group, all slots of the group side by side
    logic [SLOTS*24-1:0] r_mem_name  [GROUPS];
    logic [SLOTS*32-1:0] r_mem_score [GROUPS];
    logic [GROUPS-1:0]   r_row_valid;

    // Captured request
    t_action     r_action;
    logic [1:0]  r_group;
    logic [1:0]  r_slot;
    logic [23:0] r_name;
    logic [31:0] r_score;

    // Registered row read
    logic [SLOTS*24-1:0] r_rd_name;
    logic [SLOTS*32-1:0] r_rd_score;

    // Result register
    t_status     r_status;
    logic [1:0]  r_rank;
    logic [23:0] r_read_name;
    logic [31:0] r_read_score;

    logic [GXW-1:0]      w_gx;
    logic [GW-1:0]       w_gidx;
    logic [SXW-1:0]      w_sx;
    logic [SW-1:0]       w_sidx;
    logic                w_grp_ok;
    logic                w_slot_ok;
    logic [23:0]         w_rn [SLOTS];
    logic [31:0]         w_rs [SLOTS];
    logic [SLOTS-1:0]    w_hit;
    logic                w_found;
    logic [SW-1:0]       w_pos;
    logic [SXW-1:0]      w_posx;
    logic [23:0]         w_new_name;
    logic [SLOTS*24-1:0] w_wr_name;
    logic [SLOTS*32-1:0] w_wr_score;
    logic                w_wr_en;
    t_status             n_status;
    logic [1:0]          n_rank;
    logic [23:0]         n_read_name;
    logic [31:0]         n_read_score;

    // Index and range checks on the captured request
    assign w_gx      = GXW'(r_group);
    assign w_gidx    = w_gx[GW-1:0];
    assign w_sx      = SXW'(r_slot);
    assign w_sidx    = w_sx[SW-1:0];
    assign w_grp_ok  = ({30'd0, r_group} < 32'(GROUPS));
    assign w_slot_ok = ({30'd0, r_slot} < 32'(SLOTS));

    // Capture the request on acceptance
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_group  <= i_group;
            r_slot   <= i_slot;
            r_name   <= i_entry_name;
            r_score  <= i_entry_score;
        end
    end

    // Read the addressed row; a row never written reads as the reset contents
    always_ff @(posedge i_clk) begin
        if (i_cmd.fetch) begin
            if (w_grp_ok && r_row_valid[w_gidx]) begin
                r_rd_name  <= r_mem_name[w_gidx];
                r_rd_score <= r_mem_score[w_gidx];
            end else begin
                r_rd_name  <= {SLOTS{RESET_NAME}};
                r_rd_score <= '0;
            end
        end
    end

    // Split the row and compare every slot against the new score
    always_comb begin
        for (int p = 0; p < SLOTS; p++) begin
            w_rn[p]  = r_rd_name[p*24 +: 24];
            w_rs[p]  = r_rd_score[p*32 +: 32];
            w_hit[p] = (r_score > w_rs[p]);
        end
    end

    // First slot with a strictly lower score
    always_comb begin
        w_found = |w_hit;
        w_pos   = '0;
        for (int p = SLOTS - 1; p >= 0; p--) begin
            if (w_hit[p]) begin
                w_pos = SW'(p);
            end
        end
    end

    assign w_posx     = SXW'(w_pos);
    assign w_new_name = trim_name(r_name, NAME_CHARS);

    // Shift weaker entries down and place the new one
    always_comb begin
        for (int p = 0; p < SLOTS; p++) begin
            if (p < int'(w_pos) || p == 0) begin
                w_wr_name[p*24 +: 24]  = w_rn[p];
                w_wr_score[p*32 +: 32] = w_rs[p];
            end else begin
                w_wr_name[p*24 +: 24]  = w_rn[(p > 0) ? p - 1 : 0];
                w_wr_score[p*32 +: 32] = w_rs[(p > 0) ? p - 1 : 0];
            end
            if (p == int'(w_pos)) begin
                w_wr_name[p*24 +: 24]  = w_new_name;
                w_wr_score[p*32 +: 32] = r_score;
            end
        end
    end

    // Decode the request into its result
    always_comb begin
        n_status     = ST_INVALID;
        n_rank       = '0;
        n_read_name  = '0;
        n_read_score = '0;
        w_wr_en      = 1'b0;
        unique case (r_action)
            ACT_INSERT, ACT_PROBE: begin
                if (w_grp_ok) begin
                    if (w_found) begin
                        n_status = ST_OK;
                        n_rank   = w_posx[1:0];
                        w_wr_en  = (r_action == ACT_INSERT);
                    end else begin
                        n_status = ST_MISS;
                    end
                end
            end
            ACT_READ: begin
                if (w_grp_ok && w_slot_ok) begin
                    n_status     = ST_OK;
                    n_read_name  = w_rn[w_sidx];
                    n_read_score = w_rs[w_sidx];
                end
            end
            default: begin
                n_status = ST_INVALID;
            end
        endcase
    end

    // Write back the updated row
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_wr_en) begin
            r_mem_name[w_gidx]  <= w_wr_name;
            r_mem_score[w_gidx] <= w_wr_score;
        end
    end

    // Mark rows that hold written contents
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.exec && w_wr_en) begin
            r_row_valid[w_gidx] <= 1'b1;
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_status     <= n_status;
            r_rank       <= n_rank;
            r_read_name  <= n_read_name;
            r_read_score <= n_read_score;
        end
    end

    assign o_status     = r_status;
    assign o_rank       = r_rank;
    assign o_read_name  = r_read_name;
    assign o_read_score = r_read_score;

endmodule

`default_nettype wire

// File: design/per_group_top_k_table_core.sv
// Top level of the per-group top-k score table: stream ports, controller and datapath.
// An accepted request goes through the registered row read, then the compare-and-shift
// step, which loads the result and sets result valid; a new request is accepted only once
// the previous one is through execute, and execute waits while the previous result is not taken.
// Reset: synchronous, active low; clears control state and the row valid bits, so every
// list reads as name "---" and score 0 at once, with no clearing pass.
`default_nettype none

module per_group_top_k_table_core #(
    parameter int GROUPS     = 3,
    parameter int SLOTS      = 3,
    parameter int NAME_CHARS = 3
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [63:0] s_axis_tdata,   // group[1:0], slot[3:2], entry_name[27:4],
                                        // entry_score[59:28], zero[63:60]
    input  wire  [1:0]  s_axis_tuser,   // action[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata,   // rank[1:0], read_name[25:2], read_score[57:26],
                                        // zero[63:58]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);
    import pgtk_pkg::*;

    t_cmd        w_cmd;
    logic [1:0]  w_rank;
    logic [23:0] w_read_name;
    logic [31:0] w_read_score;

    pgtk_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (w_cmd)
    );

    pgtk_datapath #(
        .GROUPS     (GROUPS),
        .SLOTS      (SLOTS),
        .NAME_CHARS (NAME_CHARS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_action      (s_axis_tuser),
        .i_group       (s_axis_tdata[1:0]),
        .i_slot        (s_axis_tdata[3:2]),
        .i_entry_name  (s_axis_tdata[27:4]),
        .i_entry_score (s_axis_tdata[59:28]),
        .o_status      (m_axis_tuser),
        .o_rank        (w_rank),
        .o_read_name   (w_read_name),
        .o_read_score  (w_read_score)
    );

    // Pack the result transaction
    assign m_axis_tdata = {6'd0, w_read_score, w_read_name, w_rank};

endmodule

`default_nettype wire

// File: design/pgtk_checker.sv
// Port-level checks of the top-k table and their binding to the top level.
`default_nettype none

module pgtk_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [63:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);
    import pgtk_pkg::*;

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // One request at a time: no acceptance right after an acceptance
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while the previous one is in work");

    // A miss or an invalid request carries an all-zero payload
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_MISS || m_axis_tuser == ST_INVALID)
        |-> m_axis_tdata == 64'd0)
        else $error("non-zero payload on a failed request");

endmodule

bind per_group_top_k_table_core pgtk_checker u_pgtk_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: verif/per_group_top_k_table_core_tb.sv
// Testbench for the per-group top-k score table: directed and random stream traffic, checked.
`timescale 1ns / 1ps

module per_group_top_k_table_core_tb;
    import pgtk_pkg::*;

    localparam int GROUPS     = 3;
    localparam int SLOTS      = 3;
    localparam int NAME_CHARS = 3;
    localparam int RANDOM_ITEMS = 760;
    localparam int BURST_ITEMS  = 40;

    // One request as it travels on the slave side
    typedef struct {
        t_action     action;
        logic [1:0]  group;
        logic [1:0]  slot;
        logic [23:0] name;
        logic [31:0] score;
    } t_request;

    // One answer as it travels on the master side
    typedef struct {
        t_status     status;
        logic [1:0]  rank;
        logic [23:0] read_name;
        logic [31:0] read_score;
    } t_outcome;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // group[1:0], slot[3:2], entry_name[27:4],
                                      // entry_score[59:28], zero[63:60]
    logic [1:0]  s_axis_tuser = '0;   // action[1:0]
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [63:0] m_axis_tdata;        // rank[1:0], read_name[25:2], read_score[57:26],
                                      // zero[63:58]
    wire  [1:0]  m_axis_tuser;        // status[1:0]

    // Shadow copy of every list and the answers still owed by the block
    logic [23:0] ladder_name [GROUPS*SLOTS];
    logic [31:0] ladder_score[GROUPS*SLOTS];
    t_outcome    owed_outcomes[$];
    int          fault_count = 0;
    bit          no_idle = 1'b0;

    per_group_top_k_table_core #(
        .GROUPS     (GROUPS),
        .SLOTS      (SLOTS),
        .NAME_CHARS (NAME_CHARS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Generous cap on the whole run
    initial begin
        #5ms;
        $display("** per_group_top_k_table_core: FAILED **");
        $finish;
    end

    task automatic report_fault(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fault_count++;
    endtask

    // Mostly short gaps, a few long ones, none while bursting
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // Keep the leading bytes up to the first zero byte, at most NAME_CHARS of them
    function automatic logic [23:0] keep_name(input logic [23:0] raw);
        logic [23:0] kept;
        bit          stopped;
        kept    = '0;
        stopped = 1'b0;
        for (int b = 2; b >= 0; b--) begin
            if (raw[8*b +: 8] == 8'd0 || (2 - b) >= NAME_CHARS) stopped = 1'b1;
            if (!stopped) kept[8*b +: 8] = raw[8*b +: 8];
        end
        return kept;
    endfunction

    // Work out the answer to one request and apply it to the shadow lists
    function automatic t_outcome predict_outcome(input t_request req);
        t_outcome res;
        int       base;
        int       pos;
        res.status     = ST_INVALID;
        res.rank       = '0;
        res.read_name  = '0;
        res.read_score = '0;
        if (req.group < GROUPS) begin
            base = req.group * SLOTS;
            if (req.action == ACT_INSERT || req.action == ACT_PROBE) begin
                // lowest slot holding a strictly weaker score
                pos = SLOTS;
                for (int p = SLOTS - 1; p >= 0; p--) begin
                    if (req.score > ladder_score[base + p]) pos = p;
                end
                if (pos == SLOTS) begin
                    res.status = ST_MISS;
                end else begin
                    res.status = ST_OK;
                    res.rank   = pos[1:0];
                    if (req.action == ACT_INSERT) begin
                        for (int p = SLOTS - 1; p > pos; p--) begin
                            ladder_name[base + p]  = ladder_name[base + p - 1];
                            ladder_score[base + p] = ladder_score[base + p - 1];
                        end
                        ladder_name[base + pos]  = keep_name(req.name);
                        ladder_score[base + pos] = req.score;
                    end
                end
            end else if (req.action == ACT_READ && req.slot < SLOTS) begin
                res.status     = ST_OK;
                res.read_name  = ladder_name[base + req.slot];
                res.read_score = ladder_score[base + req.slot];
            end
        end
        return res;
    endfunction

    // Offer one request, hold it until accepted, then predict and idle for a random gap, if any
    task automatic send_request(input t_action action, input logic [1:0] group,
                                input logic [1:0] slot, input logic [23:0] name,
                                input logic [31:0] score);
        t_request req;
        int       gap;
        req.action = action;
        req.group  = group;
        req.slot   = slot;
        req.name   = name;
        req.score  = score;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {4'b0, score, name, slot, group};
        do @(posedge i_clk); while (!s_axis_tready);
        owed_outcomes.push_back(predict_outcome(req));
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Build a random request, mostly aimed at valid lists, half the time with scores near stored ones
    task automatic send_random_request();
        t_action     action;
        logic [1:0]  group;
        logic [23:0] name;
        logic [31:0] score;
        int          r;
        int          pick;
        r = $urandom_range(0, 99);
        if (r < 45) action = ACT_INSERT;
        else if (r < 65) action = ACT_PROBE;
        else if (r < 95) action = ACT_READ;
        else action = ACT_UNKNOWN;
        group = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, GROUPS - 1));
        name = 24'($urandom);
        if ($urandom_range(0, 4) == 0) name[8*$urandom_range(0, 2) +: 8] = 8'd0;
        r = $urandom_range(0, 99);
        if (group < GROUPS && r < 50) begin
            // tie with, or land just beside, a stored score
            pick  = group * SLOTS + $urandom_range(0, SLOTS - 1);
            score = ladder_score[pick];
            if (r >= 30) score = score + 32'($signed($urandom_range(0, 2)) - 1);
        end else if (r < 80) begin
            score = $urandom_range(0, 100);
        end else begin
            score = $urandom;
        end
        send_request(action, group, 2'($urandom_range(0, 3)), name, score);
    endtask

    // Check every accepted result and drive backpressure
    initial begin
        t_outcome want;
        int       stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (owed_outcomes.size() == 0) begin
                    report_fault($sformatf("result with nothing owed: status %0d tdata %h",
                                           m_axis_tuser, m_axis_tdata));
                end else begin
                    want = owed_outcomes.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_fault($sformatf("status %0d, want %0d",
                                               m_axis_tuser, want.status));
                    if (m_axis_tdata[1:0] !== want.rank)
                        report_fault($sformatf("rank %0d, want %0d",
                                               m_axis_tdata[1:0], want.rank));
                    if (m_axis_tdata[25:2] !== want.read_name)
                        report_fault($sformatf("read_name %h, want %h",
                                               m_axis_tdata[25:2], want.read_name));
                    if (m_axis_tdata[57:26] !== want.read_score)
                        report_fault($sformatf("read_score %h, want %h",
                                               m_axis_tdata[57:26], want.read_score));
                end
            end
            if (stall > 0) begin
                stall--;
            end else begin
                stall = pick_gap();
            end
            m_axis_tready <= (stall == 0);
        end
    end

    // Reset contents, both ends of the slot range and a group past the end
    task automatic test_reset_contents();
        for (int s = 0; s < 4; s++) send_request(ACT_READ, 2'd0, 2'(s), '0, '0);
        send_request(ACT_READ, 2'd2, 2'd2, '0, '0);
        send_request(ACT_READ, 2'd3, 2'd0, '0, '0);
    endtask

    // Ordering: top score, equal score sits below, weakest dropped, zero never enters
    task automatic test_insert_order();
        send_request(ACT_INSERT, 2'd0, 2'd0, 24'h414243, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 2'd0, 2'd3, 24'h58595A, 32'hFFFF_FFFF);
        send_request(ACT_INSERT, 2'd0, 2'd0, 24'h515253, 32'd0);
        send_request(ACT_INSERT, 2'd0, 2'd1, 24'h4A4B4C, 32'd1);
        send_request(ACT_INSERT, 2'd0, 2'd2, 24'h4D4E4F, 32'd1);
    endtask

    // Probes must answer without touching the list
    task automatic test_probe();
        send_request(ACT_PROBE, 2'd0, 2'd0, 24'hFFFFFF, 32'd2);
        send_request(ACT_PROBE, 2'd1, 2'd0, 24'h000000, 32'd0);
        send_request(ACT_PROBE, 2'd1, 2'd3, 24'h000000, 32'hFFFF_FFFF);
    endtask

    // Names cut at the first zero byte
    task automatic test_name_trim();
        send_request(ACT_INSERT, 2'd1, 2'd0, 24'h410042, 32'd5);
        send_request(ACT_INSERT, 2'd1, 2'd0, 24'h00FFFF, 32'd3);
        send_request(ACT_INSERT, 2'd1, 2'd0, 24'hFFFFFF, 32'd4);
        for (int s = 0; s < SLOTS; s++) send_request(ACT_READ, 2'd1, 2'(s), '0, '0);
    endtask

    // Bad group, unknown action, slot past the end, then the untouched list
    task automatic test_invalid_requests();
        send_request(ACT_INSERT, 2'd3, 2'd0, 24'h414141, 32'hFFFF_FFFF);
        send_request(ACT_UNKNOWN, 2'd0, 2'd0, 24'h424242, 32'hFFFF_FFFF);
        send_request(ACT_READ, 2'd2, 2'd3, '0, '0);
        for (int s = 0; s < SLOTS; s++) send_request(ACT_READ, 2'd0, 2'(s), '0, '0);
    endtask

    task automatic test_random_traffic();
        repeat (RANDOM_ITEMS) send_random_request();
    endtask

    // Back-to-back requests with the result side always ready
    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (BURST_ITEMS) send_random_request();
        no_idle = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < GROUPS * SLOTS; i++) begin
            ladder_name[i]  = RESET_NAME;
            ladder_score[i] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_contents();
        test_insert_order();
        test_probe();
        test_name_trim();
        test_invalid_requests();
        test_random_traffic();
        test_back_to_back();

        // Drain, then allow a few cycles for anything stray
        s_axis_tvalid <= 1'b0;
        while (owed_outcomes.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("** per_group_top_k_table_core: PASSED **");
        end else begin
            $display("** per_group_top_k_table_core: FAILED **");
        end
        $finish;
    end

endmodule
